@@ rtl/itar_pkg.sv @@
// Package: shared constants, control/status structs and the digit-to-ASCII function.
package itar_pkg;

    localparam int VALUE_W = 32;
    localparam int BASE_W  = 6;
    localparam int CHAR_W  = 8;
    localparam int DIGIT_W = 6;
    localparam int CNT_W   = $clog2(VALUE_W);
    localparam int DEPTH   = VALUE_W;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int PTR_W   = IDX_W + 1;

    localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
    localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);
    localparam logic [BASE_W-1:0] BASE_DEC = BASE_W'(10);

    localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(VALUE_W - 1);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic emit_sign;
        logic emit_digit;
        logic emit_empty;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic base_bad;
        logic sign_needed;
        logic step_last;
        logic quot_zero;
        logic last_digit;
        logic slot_free;
    } t_dp_status;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d < DIGIT_W'(10)) begin
            digit_char = CHAR_ZERO + d_ext;
        end else begin
            digit_char = CHAR_ALPHA + d_ext - CHAR_W'(10);
        end
    endfunction

endpackage

@@ rtl/integer_to_ascii_radix.sv @@
// Top level: integer to ASCII conversion in radix 2..36.
//
// Converts one signed 32-bit value per input beat into its ASCII digits in the
// given base, most significant digit first, one character per output beat, with
// o_last set on the final character. Digits are '0'-'9' then 'a'-'z'. A negative
// value in base 10 is preceded by '-'; in other bases the magnitude is printed
// with no sign. A base outside 2..36 yields a single beat with o_char_code = 0,
// o_last = 1 and o_empty_res = 1. Only one conversion is in flight at a time:
// o_ready is high only while the block is idle. Digits come from a shared
// one-bit-per-cycle restoring divider that works through all 32 dividend bits
// for each digit; once the quotient reaches zero, the characters follow, one
// output beat per character (N digits, plus one for a sign). A finished
// character sits in a single output register; the next one moves in at the same
// edge the consumer takes the current one, and a stalled consumer holds the
// controller. An invalid base skips division and goes straight to the empty
// beat.
module integer_to_ascii_radix
    import itar_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [BASE_W-1:0]   i_base,
    // Output channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CHAR_W-1:0]   o_char_code,
    output logic                o_last,
    output logic                o_empty_res
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Controller: accept, divide until quotient is zero, then drain the stack.
    itar_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Datapath: divider, remainder stack (pushed LSD first, popped MSD first),
    // and the output register.
    itar_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_base      (i_base),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_code (o_char_code),
        .o_last      (o_last),
        .o_empty_res (o_empty_res)
    );

    // An empty beat always closes its conversion and carries a NUL character.
    a_empty_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_empty_res |-> o_last && (o_char_code == CHAR_NONE))
        else $error("empty beat without last or with non-zero char");

    // A real character is never NUL.
    a_char_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_empty_res |-> (o_char_code != CHAR_NONE))
        else $error("non-empty beat carries NUL");

    // Once an item is taken, the input side closes until the conversion ends.
    a_one_in_flight : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready right after accepting an item");

endmodule

@@ rtl/itar_ctrl.sv @@
// Controller: sequences load, division, and character emission for one conversion.
module itar_ctrl
    import itar_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_SIGN  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_EMPTY = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.base_bad ? S_EMPTY : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.step_last && i_status.quot_zero) begin
                    n_state = i_status.sign_needed ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_status.last_digit) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMPTY: begin
                if (i_status.slot_free) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/itar_dp.sv @@
// Datapath: bit-serial divider, digit stack and output register.
module itar_dp
    import itar_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [VALUE_W-1:0]  i_value,
    input  logic [BASE_W-1:0]   i_base,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [CHAR_W-1:0]   o_char_code,
    output logic                o_last,
    output logic                o_empty_res
);

    logic [VALUE_W-1:0] r_quot;
    logic [DIGIT_W-1:0] r_rem;
    logic [BASE_W-1:0]  r_base;
    logic               r_sign;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   r_ptr;
    logic [DIGIT_W-1:0] r_digit [DEPTH];

    logic               r_ovalid;
    logic [CHAR_W-1:0]  r_char;
    logic               r_last;
    logic               r_empty;

    logic [DIGIT_W:0]   w_shift;
    logic               w_ge;
    logic [DIGIT_W:0]   w_diff;
    logic [DIGIT_W-1:0] w_rem_next;
    logic [VALUE_W-1:0] w_quot_next;
    logic [PTR_W-1:0]   w_pop;
    logic               w_slot_free;

    // One restoring division step: shift in next dividend bit, subtract if it fits.
    assign w_shift     = {r_rem, r_quot[VALUE_W-1]};
    assign w_ge        = w_shift >= {1'b0, r_base};
    assign w_diff      = w_shift - {1'b0, r_base};
    assign w_rem_next  = w_ge ? w_diff[DIGIT_W-1:0] : w_shift[DIGIT_W-1:0];
    assign w_quot_next = {r_quot[VALUE_W-2:0], w_ge};

    assign w_pop       = r_ptr - PTR_W'(1);
    assign w_slot_free = !r_ovalid || i_ready;

    assign o_status.base_bad    = (i_base < BASE_MIN) || (i_base > BASE_MAX);
    assign o_status.sign_needed = r_sign;
    assign o_status.step_last   = r_cnt == CNT_LAST;
    assign o_status.quot_zero   = w_quot_next == '0;
    assign o_status.last_digit  = r_ptr == PTR_W'(1);
    assign o_status.slot_free   = w_slot_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot <= i_value[VALUE_W-1] ? (VALUE_W'(0) - i_value) : i_value;
            r_rem  <= '0;
            r_base <= i_base;
            r_sign <= i_value[VALUE_W-1] && (i_base == BASE_DEC);
            r_cnt  <= '0;
        end else if (i_cmd.div_step) begin
            r_quot <= w_quot_next;
            r_cnt  <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_LAST) begin
                r_digit[r_ptr[IDX_W-1:0]] <= w_rem_next;
                r_rem <= '0;
            end else begin
                r_rem <= w_rem_next;
            end
        end
    end

    // Stack pointer: push at the end of each division, pop on each digit beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cmd.load) begin
            r_ptr <= '0;
        end else if (i_cmd.div_step && (r_cnt == CNT_LAST)) begin
            r_ptr <= r_ptr + PTR_W'(1);
        end else if (i_cmd.emit_digit) begin
            r_ptr <= w_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit || i_cmd.emit_empty) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_char  <= CHAR_MINUS;
            r_last  <= 1'b0;
            r_empty <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char  <= digit_char(r_digit[w_pop[IDX_W-1:0]]);
            r_last  <= r_ptr == PTR_W'(1);
            r_empty <= 1'b0;
        end else if (i_cmd.emit_empty) begin
            r_char  <= CHAR_NONE;
            r_last  <= 1'b1;
            r_empty <= 1'b1;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_char_code = r_char;
    assign o_last      = r_last;
    assign o_empty_res = r_empty;

endmodule
